[hdl/chs_pkg.sv]
// Package for the CubeHash stream hasher: shared types, constants and the round function.
// No dependencies.
`default_nettype none
package chs_pkg;
    localparam int unsigned NWORDS = 32;
    localparam logic [2:0] REG_INIT_ROUNDS  = 3'd0;
    localparam logic [2:0] REG_BLOCK_ROUNDS = 3'd1;
    localparam logic [2:0] REG_BLOCK_BYTES  = 3'd2;
    localparam logic [2:0] REG_FINAL_ROUNDS = 3'd3;
    localparam logic [2:0] REG_HASH_BYTES   = 3'd4;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;
    typedef word_t [NWORDS-1:0] state_t;

    // One full CubeHash round on the 32-word state.
    function automatic state_t cube_round(input state_t s);
        state_t a;
        state_t b;
        a = s;
        for (int i = 0; i < 16; i++) a[16+i] = a[16+i] + a[i];
        for (int i = 0; i < 16; i++) a[i] = {a[i][24:0], a[i][31:25]};
        b = a;
        for (int i = 0; i < 16; i++) b[i] = a[i ^ 8];
        for (int i = 0; i < 16; i++) b[i] = b[i] ^ b[16+i];
        a = b;
        for (int i = 0; i < 16; i++) a[16+i] = b[16+(i ^ 2)];
        for (int i = 0; i < 16; i++) a[16+i] = a[16+i] + a[i];
        for (int i = 0; i < 16; i++) a[i] = {a[i][20:0], a[i][31:21]};
        b = a;
        for (int i = 0; i < 16; i++) b[i] = a[i ^ 4];
        for (int i = 0; i < 16; i++) b[i] = b[i] ^ b[16+i];
        a = b;
        for (int i = 0; i < 16; i++) a[16+i] = b[16+(i ^ 1)];
        return a;
    endfunction
endpackage
`default_nettype wire

[hdl/cubehash_stream_hasher.sv]
// CubeHash stream hasher, one byte per input transfer. Depends on chs_pkg, chs_regs, chs_mem.
// A transfer passes S_READ and S_ABS; block_rounds rounds follow when it fills the block,
// and initial_rounds rounds come first for a message's first byte (one round per cycle).
// End of message: pad, block_rounds and final_rounds rounds, S_OREAD and S_OUT per hash word.
// One transfer at a time; input stalls while busy, at message end until the last word moves.
// Reset: registers to defaults, no message open; state memory is loaded at message start.
`default_nettype none
module cubehash_stream_hasher #(
    parameter int unsigned MAX_BLOCK_BYTES = 128,
    parameter int unsigned MAX_HASH_BYTES  = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic [7:0]  message_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic [31:0]      hash_word,
    output logic [2:0]       valid_bytes,
    output logic             last_word,
    output logic             out_valid,
    input  wire logic        out_stall
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_ABS   = 7'b0000100,
        S_ROUND = 7'b0001000,
        S_PAD   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_OREAD = 7'b1000000
    } st_t;

    typedef enum logic [1:0] {
        P_INIT = 2'd0, P_BLOCK = 2'd1, P_PADR = 2'd2, P_FIN = 2'd3
    } ph_t;

    logic [7:0] init_rounds, blk_rounds, blk_bytes, fin_rounds;
    logic [6:0] hsh_bytes;

    chs_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .init_rounds, .blk_rounds, .blk_bytes, .fin_rounds, .hsh_bytes
    );

    st_t st_reg;
    ph_t ph_reg;
    logic       open_reg;
    logic [6:0] fill_reg;
    logic [7:0] cnt_reg;
    logic [7:0] cr_reg, cf_reg, cb_reg;
    logic [6:0] ch_reg;
    logic [7:0] byte_reg;
    logic       pres_reg, eom_reg;
    logic [4:0] widx_reg;

    logic            we;
    chs_pkg::state_t wdata, rdata, rnd, absorbed;

    chs_mem u_mem (.clk, .we, .wdata, .rdata);

    assign rnd = chs_pkg::cube_round(rdata);

    logic [7:0] bb_used;
    logic [6:0] hb_used;
    always_comb
    begin
        bb_used = (blk_bytes == 8'd0) ? 8'd1 : blk_bytes;
        if (bb_used > 8'(MAX_BLOCK_BYTES)) bb_used = 8'(MAX_BLOCK_BYTES);
        hb_used = (hsh_bytes == 7'd0) ? 7'd1 : hsh_bytes;
        if (hb_used > 7'(MAX_HASH_BYTES)) hb_used = 7'(MAX_HASH_BYTES);
    end

    // Byte (or pad) absorb on the freshly read state
    logic [7:0] xv;
    logic [7:0] fill_inc;
    always_comb
    begin
        absorbed = rdata;
        xv = pres_reg ? byte_reg : chs_pkg::PAD_BYTE;
        absorbed[fill_reg[6:2]] = rdata[fill_reg[6:2]] ^ (32'(xv) << {fill_reg[1:0], 3'd0});
        fill_inc = {1'b0, fill_reg} + 8'd1;
    end

    assign in_stall = (st_reg != S_IDLE);

    logic out_fire;
    assign out_fire = out_valid && !out_stall;

    logic [6:0] left;
    assign left = ch_reg - {widx_reg, 2'b00};

    always_comb
    begin
        we = 1'b0;
        wdata = rdata;
        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid && !open_reg)
                begin
                    we = 1'b1;
                    wdata = '0;
                    wdata[0] = {25'd0, hb_used};
                    wdata[1] = {24'd0, bb_used};
                    wdata[2] = {24'd0, blk_rounds};
                end
            end
            S_ABS:   begin we = pres_reg || eom_reg; wdata = absorbed; end
            S_ROUND:
            begin
                we = 1'b1;
                if (cnt_reg != 8'd0) wdata = rnd;
            end
            S_PAD:   begin we = 1'b1; wdata[31] = rdata[31] ^ 32'd1; end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ph_reg <= P_INIT; open_reg <= 1'b0;
            fill_reg <= '0; cnt_reg <= '0; out_valid <= 1'b0; widx_reg <= '0;
            cr_reg <= 8'd16; cf_reg <= 8'd32; cb_reg <= 8'd32; ch_reg <= 7'd64;
            byte_reg <= '0; pres_reg <= 1'b0; eom_reg <= 1'b0;
            hash_word <= '0; valid_bytes <= '0; last_word <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        byte_reg <= message_byte; pres_reg <= byte_present;
                        eom_reg <= end_of_message;
                        if (!open_reg)
                        begin
                            cr_reg <= blk_rounds; cf_reg <= fin_rounds;
                            cb_reg <= bb_used; ch_reg <= hb_used;
                            open_reg <= 1'b1; fill_reg <= '0;
                            ph_reg <= P_INIT; cnt_reg <= init_rounds;
                            st_reg <= S_ROUND;
                        end
                        else
                            st_reg <= S_READ;
                    end
                end
                S_READ: st_reg <= S_ABS;
                S_ABS:
                begin
                    // Absorb byte (or pad) into the state
                    if (pres_reg)
                    begin
                        pres_reg <= 1'b0;
                        if (fill_inc >= cb_reg)
                        begin
                            fill_reg <= '0; ph_reg <= P_BLOCK; cnt_reg <= cr_reg;
                            st_reg <= S_ROUND;
                        end
                        else
                        begin
                            fill_reg <= fill_inc[6:0];
                            st_reg <= eom_reg ? S_READ : S_IDLE;
                        end
                    end
                    else if (eom_reg)
                    begin
                        ph_reg <= P_PADR; cnt_reg <= cr_reg; st_reg <= S_ROUND;
                    end
                    else
                        st_reg <= S_IDLE;
                end
                S_ROUND:
                begin
                    if (cnt_reg != 8'd0)
                        cnt_reg <= cnt_reg - 8'd1;
                    else
                    begin
                        unique case (ph_reg)
                            P_INIT:  st_reg <= S_READ;
                            P_BLOCK: st_reg <= eom_reg ? S_READ : S_IDLE;
                            P_PADR:  st_reg <= S_PAD;
                            P_FIN:
                            begin
                                widx_reg <= '0; st_reg <= S_OREAD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PAD:
                begin
                    ph_reg <= P_FIN; cnt_reg <= cf_reg; st_reg <= S_ROUND;
                end
                S_OREAD:
                begin
                    // Memory output settles after the last write
                    hash_word <= rdata[widx_reg] & ((left >= 7'd4) ? 32'hFFFF_FFFF
                                 : ((32'd1 << {left[1:0], 3'd0}) - 32'd1));
                    valid_bytes <= (left >= 7'd4) ? 3'd4 : {1'b0, left[1:0]};
                    last_word <= (left <= 7'd4);
                    out_valid <= 1'b1;
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        out_valid <= 1'b0;
                        if (last_word)
                        begin
                            open_reg <= 1'b0; fill_reg <= '0; st_reg <= S_IDLE;
                        end
                        else
                        begin
                            widx_reg <= widx_reg + 5'd1; st_reg <= S_OREAD;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/chs_regs.sv]
// APB configuration registers for the CubeHash stream hasher.
// Depends on chs_pkg.
`default_nettype none
module chs_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [7:0]       init_rounds,
    output logic [7:0]       blk_rounds,
    output logic [7:0]       blk_bytes,
    output logic [7:0]       fin_rounds,
    output logic [6:0]       hsh_bytes
);
    logic [7:0] ir_reg, br_reg, bb_reg, fr_reg;
    logic [6:0] hb_reg;
    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr  = psel && penable && pwrite;
    assign idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_reg <= 8'd16; br_reg <= 8'd16; bb_reg <= 8'd32;
            fr_reg <= 8'd32; hb_reg <= 7'd64;
        end
        else if (wr)
        begin
            unique case (idx)
                chs_pkg::REG_INIT_ROUNDS:  ir_reg <= pwdata[7:0];
                chs_pkg::REG_BLOCK_ROUNDS: br_reg <= pwdata[7:0];
                chs_pkg::REG_BLOCK_BYTES:  bb_reg <= pwdata[7:0];
                chs_pkg::REG_FINAL_ROUNDS: fr_reg <= pwdata[7:0];
                chs_pkg::REG_HASH_BYTES:   hb_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            chs_pkg::REG_INIT_ROUNDS:  prdata = {24'd0, ir_reg};
            chs_pkg::REG_BLOCK_ROUNDS: prdata = {24'd0, br_reg};
            chs_pkg::REG_BLOCK_BYTES:  prdata = {24'd0, bb_reg};
            chs_pkg::REG_FINAL_ROUNDS: prdata = {24'd0, fr_reg};
            chs_pkg::REG_HASH_BYTES:   prdata = {25'd0, hb_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign init_rounds = ir_reg;
    assign blk_rounds  = br_reg;
    assign blk_bytes   = bb_reg;
    assign fin_rounds  = fr_reg;
    assign hsh_bytes   = hb_reg;
endmodule
`default_nettype wire

[hdl/chs_mem.sv]
// State memory: 32 words of 32 bits, one row of the whole state.
// Depends on chs_pkg. Synchronous read, write data passed to the read port.
`default_nettype none
module chs_mem (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire chs_pkg::state_t wdata,
    output chs_pkg::state_t      rdata
);
    chs_pkg::state_t mem [0:0];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[0] <= wdata;
        // Forward a write so back-to-back rounds see the updated state
        rdata <= we ? wdata : mem[0];
    end
endmodule
`default_nettype wire

[hdl/chs_checker.sv]
// Port-level checker for the CubeHash stream hasher, bound to the top level.
// Depends on cubehash_stream_hasher ports only.
`default_nettype none
module chs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] hash_word,
    input wire logic [2:0]  valid_bytes,
    input wire logic        last_word
);
    a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_bytes != 3'd0 && valid_bytes <= 3'd4)) else $error("valid_bytes");
    a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_bytes != 3'd4) |-> last_word) else $error("partial not last");
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open during output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(hash_word))) else $error("hold");
endmodule
bind cubehash_stream_hasher chs_checker u_chs_checker (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .hash_word, .valid_bytes, .last_word
);
`default_nettype wire

[verif/tb_cubehash_stream_hasher.sv]
// Testbench for the CubeHash stream hasher: random messages under random idling,
// hash words checked against a behavioural CubeHash model held in a scoreboard class.
// Depends on chs_pkg (register indexes, pad byte) and the cubehash_stream_hasher RTL.
`default_nettype none
module tb_cubehash_stream_hasher;
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } hash_out_t;

    class hash_scoreboard;
        logic [31:0] st [32];
        logic [7:0]  init_rounds = 8'd16, blk_rounds = 8'd16, blk_bytes = 8'd32;
        logic [7:0]  fin_rounds = 8'd32;
        logic [6:0]  out_bytes = 7'd64;
        logic [7:0]  msg_rounds, msg_fin;
        int          msg_bbytes, msg_hbytes, fill;
        bit          open;
        hash_out_t   pending [$];
        int          errors;

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                chs_pkg::REG_INIT_ROUNDS:  init_rounds = v[7:0];
                chs_pkg::REG_BLOCK_ROUNDS: blk_rounds = v[7:0];
                chs_pkg::REG_BLOCK_BYTES:  blk_bytes = v[7:0];
                chs_pkg::REG_FINAL_ROUNDS: fin_rounds = v[7:0];
                chs_pkg::REG_HASH_BYTES:   out_bytes = v[6:0];
                default: ;
            endcase
        endfunction

        function void mix(int n);
            logic [31:0] t;
            for (int k = 0; k < n; k++)
            begin
                for (int i = 0; i < 16; i++) st[16+i] += st[i];
                for (int i = 0; i < 16; i++) st[i] = {st[i][24:0], st[i][31:25]};
                for (int i = 0; i < 8; i++)
                begin
                    t = st[i]; st[i] = st[i+8]; st[i+8] = t;
                end
                for (int i = 0; i < 16; i++) st[i] ^= st[16+i];
                for (int i = 0; i < 16; i++)
                    if (!i[1])
                    begin
                        t = st[16+i]; st[16+i] = st[18+i]; st[18+i] = t;
                    end
                for (int i = 0; i < 16; i++) st[16+i] += st[i];
                for (int i = 0; i < 16; i++) st[i] = {st[i][20:0], st[i][31:21]};
                for (int i = 0; i < 16; i++)
                    if (!i[2])
                    begin
                        t = st[i]; st[i] = st[i+4]; st[i+4] = t;
                    end
                for (int i = 0; i < 16; i++) st[i] ^= st[16+i];
                for (int i = 0; i < 16; i += 2)
                begin
                    t = st[16+i]; st[16+i] = st[17+i]; st[17+i] = t;
                end
            end
        endfunction

        function void absorb(int pos, logic [7:0] b);
            pos = pos & 127;
            st[pos >> 2] ^= 32'(b) << (8 * (pos & 3));
        endfunction

        function void note_transfer(logic [7:0] b, logic present, logic eom);
            int words, left;
            logic [31:0] w;
            if (!open)
            begin
                msg_rounds = blk_rounds;
                msg_fin = fin_rounds;
                msg_bbytes = blk_bytes == 0 ? 1 : (blk_bytes > 128 ? 128 : blk_bytes);
                msg_hbytes = out_bytes == 0 ? 1 : (out_bytes > 64 ? 64 : out_bytes);
                foreach (st[i]) st[i] = '0;
                st[0] = msg_hbytes; st[1] = msg_bbytes; st[2] = msg_rounds;
                mix(init_rounds);
                fill = 0;
                open = 1;
            end
            if (present)
            begin
                absorb(fill, b);
                fill++;
                if (fill >= msg_bbytes)
                begin
                    mix(msg_rounds);
                    fill = 0;
                end
            end
            if (!eom)
                return;
            absorb(fill, chs_pkg::PAD_BYTE);
            mix(msg_rounds);
            st[31] ^= 32'd1;
            mix(msg_fin);
            words = (msg_hbytes + 3) / 4;
            for (int k = 0; k < words; k++)
            begin
                left = msg_hbytes - 4 * k;
                w = st[k];
                if (left < 4)
                    w &= (32'd1 << (8 * left)) - 1;
                pending.push_back('{w, 3'(left > 4 ? 4 : left), k + 1 == words});
            end
            open = 0;
            fill = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_word(hash_out_t got);
            hash_out_t exp;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected hash word %h", got.word));
                return;
            end
            exp = pending.pop_front();
            if (got.word !== exp.word)
                report($sformatf("hash_word %h, want %h", got.word, exp.word));
            if (got.nbytes !== exp.nbytes)
                report($sformatf("valid_bytes %0d, want %0d", got.nbytes, exp.nbytes));
            if (got.last !== exp.last)
                report($sformatf("last_word %b, want %b", got.last, exp.last));
        endtask
    endclass

    logic        clk = 0, rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic        pready;
    logic [7:0]  message_byte = '0;
    logic        byte_present = 0, end_of_message = 0, in_valid = 0, in_stall;
    logic [31:0] hash_word;
    logic [2:0]  valid_bytes;
    logic        last_word, out_valid, out_stall = 0;
    int          out_wait = 0;

    hash_scoreboard sb = new();

    cubehash_stream_hasher uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    task write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        psel = 1; pwrite = 1; paddr = {idx, 2'b00}; pwdata = v;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task send_transfer(logic [7:0] b, logic present, logic eom);
        repeat ($urandom_range(0, 6)) @(negedge clk);
        in_valid = 1; message_byte = b; byte_present = present; end_of_message = eom;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_transfer(b, present, eom);
        @(negedge clk);
        in_valid = 0;
    endtask

    task send_message(int len);
        for (int i = 0; i < len; i++)
            send_transfer(8'($urandom_range(0, 255)), 1'b1, i == len - 1);
        if (len == 0)
            send_transfer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Drain all expected words, then let any trailing work settle before a write.
    task settle();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task set_all(int ir, int br, int bb, int fr, int hb);
        write_reg(chs_pkg::REG_INIT_ROUNDS, ir);
        write_reg(chs_pkg::REG_BLOCK_ROUNDS, br);
        write_reg(chs_pkg::REG_BLOCK_BYTES, bb);
        write_reg(chs_pkg::REG_FINAL_ROUNDS, fr);
        write_reg(chs_pkg::REG_HASH_BYTES, hb);
    endtask

    // Receiver: hold stall for a drawn number of cycles per word.
    always @(negedge clk)
    begin
        if (out_valid && out_wait != 0)
            out_wait--;
        out_stall <= (out_wait != 0);
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_word(hash_out_t'{hash_word, valid_bytes, last_word});
            out_wait = $urandom_range(0, 6);
        end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // defaults: empty message via end marker, then bytes at the extremes
        send_transfer(8'h00, 0, 1);
        send_transfer(8'hff, 1, 0);
        send_transfer(8'h00, 1, 0);
        send_transfer(8'h5a, 1, 1);
        settle();
        set_all(0, 0, 1, 0, 1);
        send_message(0);
        send_message(3);
        settle();
        set_all(255, 255, 128, 255, 64);
        send_message(2);
        settle();
        set_all(2, 1, 4, 3, 7);
        send_message(4);
        send_transfer(8'h11, 1, 0);
        settle();
        write_reg(chs_pkg::REG_HASH_BYTES, 5);
        send_transfer(8'h22, 0, 1);
        // out-of-range values are clamped; unknown index is dropped
        settle();
        set_all(1, 2, 0, 1, 0);
        write_reg(3'd7, 32'hffff_ffff);
        send_message(2);
        settle();
        set_all(4, 3, 200, 2, 100);
        send_message(1);
        for (int ph = 0; ph < 7; ph++)
        begin
            settle();
            set_all($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(1, 16),
                    $urandom_range(0, 8), $urandom_range(1, 64));
            for (int m = 0; m < 8; m++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_transfer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                else
                    send_message($urandom_range(0, 9));
            end
        end
        settle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

[cubehash_stream_hasher.f]
hdl/chs_pkg.sv
hdl/chs_regs.sv
hdl/chs_mem.sv
hdl/cubehash_stream_hasher.sv
hdl/chs_checker.sv
verif/tb_cubehash_stream_hasher.sv
